@@ rtl/core/pabs_pkg.sv @@
// Shared types and constants of the priority aging batch scheduler.
package pabs_pkg;

  localparam int unsigned MAX_TASKS  = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W      = $clog2(MAX_TASKS + 1);
  localparam int unsigned TIME_W     = 22;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned BS_W       = 17;
  localparam int unsigned PRI_W      = 27;
  localparam int unsigned RESC_W     = 6;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned ENTRY_W    = ID_W + 2 * HALF_W + BS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USER_ACTIVE = 2'd0,
    CFG_BATTERY     = 2'd1,
    CFG_TEMP        = 2'd2,
    CFG_UTIL        = 2'd3
  } cfg_idx_e;

  // Configuration reset values
  localparam logic       RST_USER_ACTIVE = 1'b1;
  localparam logic [6:0] RST_BATTERY     = 7'd100;
  localparam logic [7:0] RST_TEMP        = 8'd25;
  localparam logic [6:0] RST_UTIL        = 7'd0;

  // Penalty thresholds and cost cap
  localparam logic [6:0] BATT_LOW  = 7'd20;
  localparam logic [7:0] TEMP_HIGH = 8'd75;
  localparam logic [6:0] UTIL_HIGH = 7'd80;
  localparam logic [6:0] COST_CAP  = 7'd100;

  // Context bonuses, whole points
  localparam logic [4:0] BONUS_FG_ACTIVE = 5'd20;
  localparam logic [4:0] BONUS_BG_ACTIVE = 5'd5;
  localparam logic [4:0] BONUS_FG_IDLE   = 5'd5;
  localparam logic [4:0] BONUS_BG_IDLE   = 5'd15;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;
    logic             start;
    logic             init1;
    logic             scan1;
    logic             init2;
    logic             scan2;
    logic             calc;
    logic             last_pick;
    logic             retire;
    logic             end_batch;
    logic [IDX_W-1:0] rd_idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CNT_W-1:0] task_count;
  } stat_t;

endpackage

@@ rtl/core/pabs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pabs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/pabs_dp.sv @@
// Datapath: task table, scoring, scan trackers and result registers.
module pabs_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pabs_pkg::cmd_t                     cmd_i,
  output pabs_pkg::stat_t                    stat_o,
  input  logic [pabs_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [pabs_pkg::KIND_W-1:0]        in_kind_i,
  input  logic                               cfg_we_i,
  input  logic [pabs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pabs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [pabs_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic                               out_last_o
);
  import pabs_pkg::*;

  // Input fields
  logic [ID_W-1:0]          in_id;
  logic [HALF_W-1:0]        in_arr, in_run;
  logic [7:0]               in_base;
  logic signed [10:0]       in_score;
  logic [6:0]               in_bc, in_hc, in_lc;

  assign in_id    = in_data_i[15:0];
  assign in_arr   = in_data_i[31:16];
  assign in_run   = in_data_i[47:32];
  assign in_base  = in_data_i[55:48];
  assign in_score = $signed(in_data_i[66:56]);
  assign in_bc    = in_data_i[73:67];
  assign in_hc    = in_data_i[80:74];
  assign in_lc    = in_data_i[87:81];

  // Configuration registers
  logic       user_q;
  logic [6:0] batt_q, util_q;
  logic [7:0] temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_q <= RST_USER_ACTIVE;
      batt_q <= RST_BATTERY;
      temp_q <= RST_TEMP;
      util_q <= RST_UTIL;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_USER_ACTIVE: user_q <= cfg_data_i[0];
        CFG_BATTERY:     batt_q <= cfg_data_i[6:0];
        CFG_TEMP:        temp_q <= cfg_data_i;
        CFG_UTIL:        util_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Base score of the incoming task, in hundredths
  logic [6:0]             bc_c, hc_c, lc_c;
  logic [8:0]             pen;
  logic [4:0]             bonus;
  logic [14:0]            base100;
  logic signed [BS_W-1:0] score_x, bs;

  always_comb begin
    bc_c = (in_bc > COST_CAP) ? COST_CAP : in_bc;
    hc_c = (in_hc > COST_CAP) ? COST_CAP : in_hc;
    lc_c = (in_lc > COST_CAP) ? COST_CAP : in_lc;
    pen  = ((batt_q < BATT_LOW)  ? {2'b00, bc_c} : 9'd0)
         + ((temp_q > TEMP_HIGH) ? {2'b00, hc_c} : 9'd0)
         + ((util_q > UTIL_HIGH) ? {2'b00, lc_c} : 9'd0);
    if (user_q) begin
      bonus = (in_kind_i[0] ? BONUS_FG_ACTIVE : 5'd0)
            + (in_kind_i[1] ? BONUS_BG_ACTIVE : 5'd0);
    end else begin
      bonus = (in_kind_i[0] ? BONUS_FG_IDLE : 5'd0)
            + (in_kind_i[1] ? BONUS_BG_IDLE : 5'd0);
    end
    base100 = {7'b0, in_base} * 15'd100;
    score_x = BS_W'(in_score);
    bs = $signed({2'b00, base100}) + score_x * 17'sd10
       + $signed({12'b0, bonus}) * 17'sd10 - $signed({8'b0, pen}) * 17'sd5;
  end

  // Task table
  logic [CNT_W-1:0]   count_q;
  logic               full;
  logic [ENTRY_W-1:0] rdata;

  assign full = (count_q == CNT_W'(MAX_TASKS));

  pabs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({bs, in_run, in_arr, in_id}),
    .raddr_i (cmd_i.rd_idx),
    .rdata_o (rdata)
  );

  logic [ID_W-1:0]        r_id;
  logic [HALF_W-1:0]      r_arr, r_run;
  logic signed [BS_W-1:0] r_bs;

  assign r_id  = rdata[15:0];
  assign r_arr = rdata[31:16];
  assign r_run = rdata[47:32];
  assign r_bs  = $signed(rdata[64:48]);

  // Scan state
  logic                    v1_q, v2_q;
  logic [IDX_W-1:0]        idx_q;
  logic [MAX_TASKS-1:0]    done_q;
  logic [TIME_W-1:0]       tick_q, worst_q;
  logic [RESC_W-1:0]       picks_q;
  logic                    any_q, have_q, first_q;
  logic [HALF_W-1:0]       min_q;
  logic signed [PRI_W-1:0] sel_p_q;
  logic [IDX_W-1:0]        sel_idx_q, plain_idx_q;
  logic [ID_W-1:0]         sel_id_q, plain_id_q;
  logic [HALF_W-1:0]       sel_arr_q, sel_run_q, plain_arr_q;
  logic signed [BS_W-1:0]  plain_bs_q;
  logic [TIME_W-1:0]       fin_q;

  // Candidate compare against the current entry
  logic                    r_ready;
  logic [TIME_W-1:0]       r_wait;
  logic [24:0]             w5;
  logic signed [PRI_W-1:0] r_pri;
  logic                    beats_sel, beats_plain;

  always_comb begin
    r_ready = !done_q[idx_q] && ({6'b0, r_arr} <= tick_q);
    r_wait  = tick_q - {6'b0, r_arr};
    w5      = {1'b0, r_wait, 2'b00} + {3'b000, r_wait};
    r_pri   = PRI_W'(r_bs) + $signed({2'b00, w5});
    beats_sel = (r_pri > sel_p_q) || ((r_pri == sel_p_q) &&
                ((r_arr < sel_arr_q) || ((r_arr == sel_arr_q) && (r_id < sel_id_q))));
    beats_plain = (r_bs > plain_bs_q) || ((r_bs == plain_bs_q) &&
                  ((r_arr < plain_arr_q) ||
                   ((r_arr == plain_arr_q) && (r_id < plain_id_q))));
  end

  // Result fields of the chosen task
  logic [TIME_W-1:0] c_fin, c_wait, c_turn;
  logic              c_aged;
  logic [RESC_W-1:0] c_picks;

  always_comb begin
    c_fin   = tick_q + {6'b0, sel_run_q};
    c_wait  = tick_q - {6'b0, sel_arr_q};
    c_turn  = c_fin - {6'b0, sel_arr_q};
    c_aged  = (sel_idx_q != plain_idx_q);
    c_picks = picks_q + {{(RESC_W-1){1'b0}}, c_aged};
  end

  // Control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      count_q <= '0;
      done_q  <= '0;
      tick_q  <= '0;
      worst_q <= '0;
      picks_q <= '0;
    end else begin
      v1_q <= cmd_i.scan1;
      v2_q <= cmd_i.scan2;
      if (cmd_i.load && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.start) begin
        tick_q  <= '0;
        worst_q <= '0;
        picks_q <= '0;
      end
      if (cmd_i.init2 && !any_q) begin
        tick_q <= {6'b0, min_q};
      end
      if (v2_q && r_ready && (r_wait > worst_q)) begin
        worst_q <= r_wait;
      end
      if (cmd_i.calc) begin
        picks_q <= c_picks;
      end
      if (cmd_i.end_batch) begin
        done_q  <= '0;
        count_q <= '0;
        tick_q  <= '0;
      end else if (cmd_i.retire) begin
        done_q[sel_idx_q] <= 1'b1;
        tick_q            <= fin_q;
      end
    end
  end

  // Scan trackers and result payload
  always_ff @(posedge clk_i) begin
    idx_q <= cmd_i.rd_idx;
    if (cmd_i.init1) begin
      any_q  <= 1'b0;
      have_q <= 1'b0;
    end
    if (v1_q && !done_q[idx_q]) begin
      if ({6'b0, r_arr} <= tick_q) begin
        any_q <= 1'b1;
      end
      if (!have_q || (r_arr < min_q)) begin
        min_q  <= r_arr;
        have_q <= 1'b1;
      end
    end
    if (cmd_i.init2) begin
      first_q <= 1'b1;
    end
    if (v2_q && r_ready) begin
      first_q <= 1'b0;
      if (first_q || beats_sel) begin
        sel_p_q   <= r_pri;
        sel_idx_q <= idx_q;
        sel_id_q  <= r_id;
        sel_arr_q <= r_arr;
        sel_run_q <= r_run;
      end
      if (first_q || beats_plain) begin
        plain_bs_q  <= r_bs;
        plain_idx_q <= idx_q;
        plain_id_q  <= r_id;
        plain_arr_q <= r_arr;
      end
    end
    if (cmd_i.calc) begin
      fin_q      <= c_fin;
      out_data_o <= {3'b000, c_picks, worst_q, c_aged, c_turn, c_wait, c_fin,
                     tick_q, sel_id_q};
      out_last_o <= cmd_i.last_pick;
    end
  end

  assign stat_o.task_count = count_q;

endmodule

@@ rtl/core/pabs_ctrl.sv @@
// Controller: load, two scan passes per pick, result handoff.
module pabs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pabs_pkg::stat_t stat_i,
  output pabs_pkg::cmd_t  cmd_o
);
  import pabs_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_P1,
    S_P1D,
    S_P2,
    S_P2D,
    S_CALC,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] scan_q, scan_d, pick_q, pick_d;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer, out_xfer, scan_last, pick_last;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign scan_last   = ((scan_q + 1'b1) == stat_i.task_count);
  assign pick_last   = ((pick_q + 1'b1) == stat_i.task_count);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    pick_d      = pick_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_idx    = scan_q[IDX_W-1:0];
    cmd_o.last_pick = pick_last;
    case (state_q)
      S_LOAD: begin
        cmd_o.load = in_xfer;
        if (in_xfer && in_last_i) begin
          cmd_o.start = 1'b1;
          scan_d      = '0;
          pick_d      = '0;
          state_d     = S_P1;
        end
      end
      S_P1: begin
        cmd_o.scan1 = 1'b1;
        cmd_o.init1 = (scan_q == '0);
        scan_d      = scan_q + 1'b1;
        if (scan_last) begin
          state_d = S_P1D;
        end
      end
      S_P1D: begin
        scan_d  = '0;
        state_d = S_P2;
      end
      S_P2: begin
        cmd_o.scan2 = 1'b1;
        cmd_o.init2 = (scan_q == '0);
        scan_d      = scan_q + 1'b1;
        if (scan_last) begin
          state_d = S_P2D;
        end
      end
      S_P2D: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          cmd_o.retire = 1'b1;
          out_valid_d  = 1'b0;
          pick_d       = pick_q + 1'b1;
          scan_d       = '0;
          if (pick_last) begin
            cmd_o.end_batch = 1'b1;
            state_d         = S_LOAD;
          end else begin
            state_d = S_P1;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      scan_q      <= '0;
      pick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pick_q      <= pick_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/priority_aging_batch_scheduler_core.sv @@
// Top level of the priority aging batch scheduler.
//
// Task records arrive on the slave stream, one transfer per cycle while the
// block is loading; tlast marks the final record of a batch. Up to MAX_TASKS
// records are stored; further non-final records are dropped, and a final
// record that finds the table full is dropped while the batch still runs.
// After the final record the block runs a non-preemptive priority schedule
// with aging and sends one result per task, in run order, on the master
// stream; tlast marks the last result. Each pick scans the table twice
// through the single read port of the task RAM (earliest pending arrival,
// then best aged priority). The slave side is not ready while results are
// being produced; a stalled result simply holds the block.
// Reset clears the table count, completion flags, counters and sets the
// configuration registers to their defaults; no clearing pass is needed.
// Configuration writes are taken in any cycle and apply to later loads.
module priority_aging_batch_scheduler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // task_id, arrival_time, run_length, base_priority, context_score,
  // battery_cost, heat_cost, load_cost
  input  logic [pabs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // task_kind
  input  logic [pabs_pkg::KIND_W-1:0]         s_axis_tuser,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // task_id_res, start_time, finish_time, wait_time, turnaround_time,
  // aged_choice, max_wait, rescued_count, zero pad
  output logic [pabs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [pabs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pabs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pabs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pabs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

  // Loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // A final record starts scheduling
  a_sched_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("still loading after final record");

  // The last result returns the block to loading
  a_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not loading after last result");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the priority aging batch scheduler core.
`timescale 1ns / 100ps

module testbench;
  import pabs_pkg::*;

  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RAND_ITEMS  = 456;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 24;
  localparam int unsigned TAIL_WAIT   = 200;

  // One task record as it enters the block
  typedef struct packed {
    logic [15:0]        id;
    logic [15:0]        arr;
    logic [15:0]        run;
    logic [7:0]         base;
    logic signed [10:0] score;
    logic [6:0]         bat;
    logic [6:0]         heat;
    logic [6:0]         load;
    logic [1:0]         kind;
    logic               last;
  } task_rec_t;

  // One scheduled task as it leaves the block
  typedef struct packed {
    logic [15:0] id;
    logic [21:0] start;
    logic [21:0] fin;
    logic [21:0] wt;
    logic [21:0] turn;
    logic        aged;
    logic [21:0] max_wait;
    logic [5:0]  rescued;
    logic        last;
  } sched_res_t;

  // Stored task entry of the prediction table
  typedef struct {
    logic [15:0] id;
    logic [15:0] arr;
    logic [15:0] run;
    int          bs;
  } task_ent_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor state
  task_ent_t  task_tbl[$];
  sched_res_t sched_q[$];
  logic       cfg_user;
  logic [6:0] cfg_batt;
  logic [7:0] cfg_temp;
  logic [6:0] cfg_util;

  int  mismatches = 0;
  int  cycles = 0;
  int  rx_gap = 0;
  int  items_sent = 0;
  bit  hold_rx = 1'b0;
  bit  hold_req = 1'b0;

  priority_aging_batch_scheduler_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL priority_aging_batch_scheduler_core");
      $finish;
    end
  end

  function automatic int clamp_cost(logic [6:0] c);
    return (c > COST_CAP) ? int'(COST_CAP) : int'(c);
  endfunction

  // Candidate i beats incumbent j: priority, then earlier arrival, then lower id
  function automatic bit outranks(longint pa, int i, longint pb, int j);
    if (pa != pb) return pa > pb;
    if (task_tbl[i].arr != task_tbl[j].arr) return task_tbl[i].arr < task_tbl[j].arr;
    return task_tbl[i].id < task_tbl[j].id;
  endfunction

  // Run the stored batch and queue its run order; returns the result count
  function automatic int schedule_batch();
    int          n, k, i, sel, plain;
    logic [21:0] tick, wt, fin, min_arr, worst;
    logic [5:0]  picks;
    bit          any_ready, have_min, first;
    longint      p, sel_p;
    bit          done[MAX_TASKS];
    sched_res_t  r;
    n = task_tbl.size();
    tick = '0;
    worst = '0;
    picks = '0;
    for (i = 0; i < MAX_TASKS; i++) done[i] = 1'b0;
    for (k = 0; k < n; k++) begin
      any_ready = 1'b0;
      have_min = 1'b0;
      min_arr = '0;
      for (i = 0; i < n; i++) begin
        if (done[i]) continue;
        if (task_tbl[i].arr <= tick) any_ready = 1'b1;
        if (!have_min || task_tbl[i].arr < min_arr) begin
          min_arr = 22'(task_tbl[i].arr);
          have_min = 1'b1;
        end
      end
      if (!any_ready) tick = min_arr;
      first = 1'b1;
      sel = 0;
      plain = 0;
      sel_p = 0;
      for (i = 0; i < n; i++) begin
        if (done[i] || task_tbl[i].arr > tick) continue;
        wt = tick - 22'(task_tbl[i].arr);
        if (wt > worst) worst = wt;
        p = longint'(task_tbl[i].bs) + 5 * longint'(wt);
        if (first) begin
          sel = i;
          plain = i;
          sel_p = p;
          first = 1'b0;
        end else begin
          if (outranks(p, i, sel_p, sel)) begin
            sel = i;
            sel_p = p;
          end
          if (outranks(task_tbl[i].bs, i, task_tbl[plain].bs, plain)) plain = i;
        end
      end
      if (sel != plain) picks = picks + 1'b1;
      fin = tick + 22'(task_tbl[sel].run);
      r.id = task_tbl[sel].id;
      r.start = tick;
      r.fin = fin;
      r.wt = tick - 22'(task_tbl[sel].arr);
      r.turn = fin - 22'(task_tbl[sel].arr);
      r.aged = (sel != plain);
      r.max_wait = worst;
      r.rescued = picks;
      r.last = (k + 1 == n);
      sched_q = {sched_q, r};
      done[sel] = 1'b1;
      tick = fin;
    end
    task_tbl.delete();
    return n;
  endfunction

  // Store one accepted record; schedule when it closes the batch
  function automatic int absorb_record(task_rec_t t);
    int        bonus, pen;
    task_ent_t e;
    if (task_tbl.size() < MAX_TASKS) begin
      bonus = 0;
      pen = 0;
      if (cfg_user) begin
        if (t.kind[0]) bonus += BONUS_FG_ACTIVE;
        if (t.kind[1]) bonus += BONUS_BG_ACTIVE;
      end else begin
        if (t.kind[0]) bonus += BONUS_FG_IDLE;
        if (t.kind[1]) bonus += BONUS_BG_IDLE;
      end
      if (cfg_batt < BATT_LOW) pen += clamp_cost(t.bat);
      if (cfg_temp > TEMP_HIGH) pen += clamp_cost(t.heat);
      if (cfg_util > UTIL_HIGH) pen += clamp_cost(t.load);
      e.id = t.id;
      e.arr = t.arr;
      e.run = t.run;
      e.bs = int'(t.base) * 100 + int'(t.score) * 10 + bonus * 10 - pen * 5;
      task_tbl = {task_tbl, e};
    end
    if (!t.last) return 0;
    return schedule_batch();
  endfunction

  // Compare one result transfer with the oldest expectation
  task automatic check_result(input logic [OUT_DATA_W-1:0] d, input logic l);
    sched_res_t act, exp_r;
    act.id = d[15:0];
    act.start = d[37:16];
    act.fin = d[59:38];
    act.wt = d[81:60];
    act.turn = d[103:82];
    act.aged = d[104];
    act.max_wait = d[126:105];
    act.rescued = d[132:127];
    act.last = l;
    if (sched_q.size() == 0) begin
      if (mismatches < 10) $display("result with nothing pending: id %0d", act.id);
      mismatches++;
    end else begin
      exp_r = sched_q.pop_front();
      if (act !== exp_r) begin
        if (mismatches < 10) begin
          $display("mismatch exp id %0d st %0d fin %0d wt %0d ta %0d aged %0d mw %0d rc %0d",
                   exp_r.id, exp_r.start, exp_r.fin, exp_r.wt, exp_r.turn, exp_r.aged,
                   exp_r.max_wait, exp_r.rescued);
          $display("         exp last %0d", exp_r.last);
          $display("         act id %0d st %0d fin %0d wt %0d ta %0d aged %0d mw %0d rc %0d",
                   act.id, act.start, act.fin, act.wt, act.turn, act.aged,
                   act.max_wait, act.rescued);
          $display("         act last %0d", act.last);
        end
        mismatches++;
      end
    end
  endtask

  // Receive results; stall at random, with calm stretches and forced holds
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
    if (!rst_ni || hold_rx) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ((cycles / 700) % 3 == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: rx_gap <= int'($urandom_range(1, 3));
        3:       rx_gap <= int'($urandom_range(10, 40));
        default: rx_gap <= 0;
      endcase
      m_axis_tready <= 1'b1;
    end
  end

  // Hold the receiver off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // Offer one record after a random gap and wait for its transfer
  task automatic send_record(input task_rec_t t, output int n_res);
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = int'($urandom_range(1, 3));
      4:          gap = int'($urandom_range(10, 40));
      default:    gap = 0;
    endcase
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {t.load, t.heat, t.bat, t.score, t.base, t.run, t.arr, t.id};
    s_axis_tuser <= t.kind;
    s_axis_tlast <= t.last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_res = absorb_record(t);
    items_sent++;
  endtask

  // Wait until the block is idle, then write one register
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    s_axis_tvalid <= 1'b0;
    while (sched_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_USER_ACTIVE: cfg_user = val[0];
      CFG_BATTERY:     cfg_batt = val[6:0];
      CFG_TEMP:        cfg_temp = val;
      default:         cfg_util = val[6:0];
    endcase
  endtask

  function automatic task_rec_t mk_rec(int id, int arr, int run, int base, int score,
                                       int bat, int heat, int load, int kind, bit last);
    task_rec_t t;
    t.id = 16'(id);
    t.arr = 16'(arr);
    t.run = 16'(run);
    t.base = 8'(base);
    t.score = 11'(score);
    t.bat = 7'(bat);
    t.heat = 7'(heat);
    t.load = 7'(load);
    t.kind = 2'(kind);
    t.last = last;
    return t;
  endfunction

  function automatic sched_res_t mk_res(int id, int start, int fin, int wt, int turn);
    sched_res_t r;
    r = '0;
    r.id = 16'(id);
    r.start = 22'(start);
    r.fin = 22'(fin);
    r.wt = 22'(wt);
    r.turn = 22'(turn);
    r.last = 1'b1;
    return r;
  endfunction

  // Random record: mostly tight ranges to force contention, sometimes full width
  function automatic task_rec_t rand_rec(bit last);
    task_rec_t t;
    bit wide;
    wide = ($urandom_range(0, 4) == 0);
    t.id = 16'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 15));
    t.arr = 16'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 150));
    t.run = 16'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 60));
    t.base = 8'(wide ? $urandom_range(0, 255) : $urandom_range(0, 6));
    t.score = 11'(wide ? $urandom_range(0, 2047) : $urandom_range(0, 2000) - 1000);
    t.bat = 7'($urandom_range(0, 127));
    t.heat = 7'($urandom_range(0, 127));
    t.load = 7'($urandom_range(0, 127));
    t.kind = 2'($urandom_range(0, 3));
    t.last = last;
    return t;
  endfunction

  task_rec_t  dir_rec[14];
  bit         dir_has_exp[14];
  sched_res_t dir_exp[14];

  initial begin
    int         n_res, i, sz, batch;
    task_rec_t  t;
    cfg_user = RST_USER_ACTIVE;
    cfg_batt = RST_BATTERY;
    cfg_temp = RST_TEMP;
    cfg_util = RST_UTIL;

    // Directed rows: single-task extremes, aging rescue, ties, idle jump, penalties
    dir_rec[0]  = mk_rec(5, 0, 10, 0, 0, 0, 0, 0, 0, 1);
    dir_rec[1]  = mk_rec(65535, 65535, 65535, 255, 1000, 127, 127, 127, 3, 1);
    dir_rec[2]  = mk_rec(0, 0, 0, 0, -1000, 0, 0, 0, 0, 1);
    dir_rec[3]  = mk_rec(1, 0, 50, 50, 0, 0, 0, 0, 0, 0);
    dir_rec[4]  = mk_rec(2, 0, 100, 1, 0, 0, 0, 0, 0, 0);
    dir_rec[5]  = mk_rec(3, 40, 100, 2, 0, 0, 0, 0, 0, 1);
    dir_rec[6]  = mk_rec(9, 5, 3, 10, 0, 0, 0, 0, 0, 0);
    dir_rec[7]  = mk_rec(4, 5, 3, 10, 0, 0, 0, 0, 0, 0);
    dir_rec[8]  = mk_rec(7, 2, 3, 10, 0, 0, 0, 0, 0, 0);
    dir_rec[9]  = mk_rec(8, 300, 1, 0, -1000, 0, 0, 0, 1, 0);
    dir_rec[10] = mk_rec(6, 2, 0, 255, 1000, 0, 0, 0, 2, 1);
    dir_rec[11] = mk_rec(20, 0, 5, 100, 0, 0, 50, 127, 1, 0);
    dir_rec[12] = mk_rec(21, 0, 5, 100, 0, 127, 100, 101, 2, 0);
    dir_rec[13] = mk_rec(22, 1, 5, 90, -5, 99, 0, 1, 3, 1);
    for (i = 0; i < 14; i++) dir_has_exp[i] = 1'b0;
    dir_has_exp[0] = 1'b1;
    dir_exp[0] = mk_res(5, 0, 10, 0, 10);
    dir_has_exp[1] = 1'b1;
    dir_exp[1] = mk_res(65535, 65535, 131070, 0, 65535);
    dir_has_exp[2] = 1'b1;
    dir_exp[2] = mk_res(0, 0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings, then with every penalty on
    for (i = 0; i < 14; i++) begin
      if (i == 11) begin
        write_reg(CFG_USER_ACTIVE, 8'd0);
        write_reg(CFG_BATTERY, 8'd0);
        write_reg(CFG_TEMP, 8'd150);
        write_reg(CFG_UTIL, 8'd100);
      end
      send_record(dir_rec[i], n_res);
      if (dir_has_exp[i]) begin
        repeat (n_res) void'(sched_q.pop_back());
        sched_q = {sched_q, dir_exp[i]};
      end
    end

    // Random batches under changing settings
    batch = 0;
    while (items_sent < 14 + RAND_ITEMS) begin
      if (batch % 4 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            write_reg(CFG_USER_ACTIVE, 8'd1);
            write_reg(CFG_BATTERY, 8'd100);
            write_reg(CFG_TEMP, 8'd0);
            write_reg(CFG_UTIL, 8'd0);
          end
          1: begin
            write_reg(CFG_USER_ACTIVE, 8'hFE);
            write_reg(CFG_BATTERY, 8'd19);
            write_reg(CFG_TEMP, 8'd76);
            write_reg(CFG_UTIL, 8'd81);
          end
          2: begin
            write_reg(CFG_USER_ACTIVE, 8'd1);
            write_reg(CFG_BATTERY, 8'd20);
            write_reg(CFG_TEMP, 8'd75);
            write_reg(CFG_UTIL, 8'd80);
          end
          default: begin
            write_reg(CFG_USER_ACTIVE, 8'($urandom_range(0, 255)));
            write_reg(CFG_BATTERY, 8'($urandom_range(0, 255)));
            write_reg(CFG_TEMP, 8'($urandom_range(0, 255)));
            write_reg(CFG_UTIL, 8'($urandom_range(0, 255)));
          end
        endcase
      end
      case ($urandom_range(0, 11))
        0:       sz = MAX_TASKS + int'($urandom_range(0, 2));
        1:       sz = int'($urandom_range(9, MAX_TASKS));
        default: sz = int'($urandom_range(1, 8));
      endcase
      for (i = 0; i < sz; i++) begin
        // Long receiver hold-off from the final record on, while the next batch is offered
        if (batch == 5 && i == sz - 1) hold_req = 1'b1;
        t = rand_rec(i == sz - 1);
        send_record(t, n_res);
      end
      batch++;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;

    while (sched_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS priority_aging_batch_scheduler_core");
    end else begin
      $display("FAIL priority_aging_batch_scheduler_core");
    end
    $finish;
  end

endmodule
